[src/mpix_pkg.sv]
// shared types, constants and codes for the mosaic pixelation block
`timescale 1ns / 1ps
package mpix_pkg;

  // default geometry
  localparam int BLOCK_DEF     = 11;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;

  // register and pixel widths
  localparam int CFG_W  = 12;
  localparam int CH_W   = 8;
  localparam int PX_W   = 3 * CH_W;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  // register reset values
  localparam int WIDTH_RESET  = 1280;
  localparam int HEIGHT_RESET = 720;

  // input word command codes
  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } mpix_cmd_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } mpix_reg_t;

  typedef struct packed {
    mpix_cmd_t         command;
    logic [CH_W-1:0]   pixel_ch0;
    logic [CH_W-1:0]   pixel_ch1;
    logic [CH_W-1:0]   pixel_ch2;
  } mpix_in_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_ch0;
    logic [CH_W-1:0]   out_ch1;
    logic [CH_W-1:0]   out_ch2;
    logic              last;
  } mpix_out_t;

  // raster position status
  typedef struct packed {
    logic full;       // position lies in a full square
    logic at_center;  // position is a square's center offset
    logic at_last;    // final pixel of the region
  } mpix_pos_flags_t;

  // per-word info carried alongside the memory reads
  typedef struct packed {
    logic              use_center;
    logic              fwd;
    logic [PX_W-1:0]   fwd_px;
    logic              last;
  } mpix_meta_t;

endpackage

[src/mpix_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module mpix_ram #(
  parameter int WIDTH  = mpix_pkg::PX_W,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when both ports hit one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/mpix_pos.sv]
// raster position tracker with square offsets and column-of-squares index
`timescale 1ns / 1ps
module mpix_pos #(
  parameter int BLOCK     = mpix_pkg::BLOCK_DEF,
  parameter int MAX_WIDTH = mpix_pkg::MAX_WIDTH_DEF,
  parameter int SLOT_W    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [mpix_pkg::CFG_W-1:0] eff_w,
  input  logic [mpix_pkg::CFG_W-1:0] eff_h,
  output logic [SLOT_W-1:0]          slot,
  output mpix_pkg::mpix_pos_flags_t  flags
);
  import mpix_pkg::*;

  localparam int HALF  = (BLOCK - 1) / 2;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int MOD_W = $clog2(BLOCK);
  localparam int CMP_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] c0;
  logic [MOD_W-1:0] cmod;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] r0;
  logic [MOD_W-1:0] rmod;

  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;
  logic             row_end;
  logic             region_end;

  // end-of-row and end-of-region tests
  assign col_inc    = CMP_W'(col) + CMP_W'(1);
  assign row_inc    = CMP_W'(row) + CMP_W'(1);
  assign row_end    = col_inc >= CMP_W'(eff_w);
  assign region_end = row_inc >= CMP_W'(eff_h);

  // status flags
  assign flags.full = ((CMP_W'(c0) + CMP_W'(BLOCK)) <= CMP_W'(eff_w))
                   && ((CMP_W'(r0) + CMP_W'(BLOCK)) <= CMP_W'(eff_h));
  assign flags.at_center = (cmod == MOD_W'(HALF)) && (rmod == MOD_W'(HALF));
  assign flags.at_last   = (col_inc == CMP_W'(eff_w)) && (row_inc == CMP_W'(eff_h));

  // advance one pixel in raster order
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      c0   <= '0;
      cmod <= '0;
      slot <= '0;
      row  <= '0;
      r0   <= '0;
      rmod <= '0;
    end else if (step) begin
      if (row_end) begin
        col  <= '0;
        c0   <= '0;
        cmod <= '0;
        slot <= '0;
        if (region_end) begin
          row  <= '0;
          r0   <= '0;
          rmod <= '0;
        end else begin
          row <= row + ROW_W'(1);
          if (rmod == MOD_W'(BLOCK - 1)) begin
            rmod <= '0;
            r0   <= r0 + ROW_W'(BLOCK);
          end else begin
            rmod <= rmod + MOD_W'(1);
          end
        end
      end else begin
        col <= col + COL_W'(1);
        if (cmod == MOD_W'(BLOCK - 1)) begin
          cmod <= '0;
          c0   <= c0 + COL_W'(BLOCK);
          slot <= slot + SLOT_W'(1);
        end else begin
          cmod <= cmod + MOD_W'(1);
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cmod_range: assert property (@(posedge clk) disable iff (rst)
    cmod < MOD_W'(BLOCK) && rmod < MOD_W'(BLOCK))
    else $error("square offset out of range");
`endif

endmodule

[src/mpix_ctrl.sv]
// word acceptance, delay ring pointers, positions and memory access issue
`timescale 1ns / 1ps
module mpix_ctrl #(
  parameter int BLOCK     = mpix_pkg::BLOCK_DEF,
  parameter int MAX_WIDTH = mpix_pkg::MAX_WIDTH_DEF,
  parameter int DA_W      = 14,
  parameter int CA_W      = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       pixel_valid,
  output logic                       pixel_ready,
  input  mpix_pkg::mpix_in_t         pixel,
  input  logic                       can_take,
  // configuration
  input  logic                       cfg_valid,
  input  mpix_pkg::mpix_reg_t        cfg_index,
  input  logic [mpix_pkg::CFG_W-1:0] cfg_data,
  // delay memory
  output logic                       dly_we,
  output logic [DA_W-1:0]            dly_waddr,
  output logic                       dly_re,
  output logic [DA_W-1:0]            dly_raddr,
  // center memory
  output logic                       ctr_we,
  output logic [CA_W-1:0]            ctr_waddr,
  output logic                       ctr_re,
  output logic [CA_W-1:0]            ctr_raddr,
  output logic [mpix_pkg::PX_W-1:0]  px,
  // read issue toward the output stage
  output logic                       issue,
  output mpix_pkg::mpix_meta_t       meta
);
  import mpix_pkg::*;

  localparam int HALF      = (BLOCK - 1) / 2;
  localparam int DELAY_CAP = HALF * MAX_WIDTH + HALF;
  localparam int PEND_W    = $clog2(DELAY_CAP + 1);
  localparam int SLOT_MAX  = (MAX_WIDTH - 1) / BLOCK;
  localparam int SLOT_W    = (SLOT_MAX > 0) ? $clog2(SLOT_MAX + 1) : 1;
  localparam int CMP_W     = CFG_W + 1;
  localparam int W_RST     = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int H_RST     = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [CFG_W-1:0]  eff_w;
  logic [CFG_W-1:0]  eff_h;
  logic [CFG_W-1:0]  clamp_w;
  logic [CFG_W-1:0]  clamp_h;

  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;
  logic [DA_W-1:0]   wr_ptr;
  logic [DA_W-1:0]   rd_ptr;
  logic [PEND_W-1:0] delay_len;

  logic              accept;
  logic              is_flush;
  logic              pixel_go;
  logic              has_pending;
  logic              emit;
  logic              store;
  logic              capture;

  logic [SLOT_W-1:0] in_slot;
  logic [SLOT_W-1:0] out_slot;
  mpix_pos_flags_t   in_flags;
  mpix_pos_flags_t   out_flags;

  // register writes, held as effective clamped values
  assign clamp_w = (cfg_data == '0) ? CFG_W'(1)
                 : ((CMP_W'(cfg_data) > CMP_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_data);
  assign clamp_h = (cfg_data == '0) ? CFG_W'(1)
                 : ((CMP_W'(cfg_data) > CMP_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= CFG_W'(W_RST);
      eff_h <= CFG_W'(H_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  eff_w <= clamp_w;
        REG_HEIGHT: eff_h <= clamp_h;
      endcase
    end
  end

  // decisions for the word at the input
  assign pixel_ready = can_take;
  assign accept      = pixel_valid && pixel_ready;
  assign is_flush    = pixel.command == CMD_FLUSH;
  assign pixel_go    = accept && !is_flush;
  assign px          = {pixel.pixel_ch2, pixel.pixel_ch1, pixel.pixel_ch0};
  assign delay_len   = PEND_W'(HALF) * PEND_W'(eff_w) + PEND_W'(HALF);
  assign has_pending = pending != '0;
  assign emit        = is_flush ? has_pending : (has_pending && pending >= delay_len);
  assign issue       = accept && emit;
  assign store       = pixel_go && (pending != PEND_W'(DELAY_CAP) || emit);
  assign capture     = pixel_go && in_flags.at_center && in_flags.full;

  // memory requests
  assign dly_we    = store;
  assign dly_waddr = wr_ptr;
  assign dly_re    = issue;
  assign dly_raddr = rd_ptr;
  assign ctr_we    = capture;
  assign ctr_waddr = CA_W'(in_slot);
  assign ctr_re    = issue;
  assign ctr_raddr = CA_W'(out_slot);

  // center captured by this same word is forwarded past the memory
  assign meta.use_center = out_flags.full;
  assign meta.fwd        = capture && (in_slot == out_slot);
  assign meta.fwd_px     = px;
  assign meta.last       = out_flags.at_last;

  // fill count and ring pointers
  always_comb begin
    case ({issue, store})
      2'b10:   pending_next = pending - PEND_W'(1);
      2'b01:   pending_next = pending + PEND_W'(1);
      default: pending_next = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
    end else begin
      pending <= pending_next;
      if (store) begin
        wr_ptr <= (wr_ptr == DA_W'(DELAY_CAP - 1)) ? '0 : wr_ptr + DA_W'(1);
      end
      if (issue) begin
        rd_ptr <= (rd_ptr == DA_W'(DELAY_CAP - 1)) ? '0 : rd_ptr + DA_W'(1);
      end
    end
  end

  // input and output raster positions
  mpix_pos #(
    .BLOCK     (BLOCK),
    .MAX_WIDTH (MAX_WIDTH),
    .SLOT_W    (SLOT_W)
  ) u_in_pos (
    .clk   (clk),
    .rst   (rst),
    .step  (pixel_go),
    .eff_w (eff_w),
    .eff_h (eff_h),
    .slot  (in_slot),
    .flags (in_flags)
  );

  mpix_pos #(
    .BLOCK     (BLOCK),
    .MAX_WIDTH (MAX_WIDTH),
    .SLOT_W    (SLOT_W)
  ) u_out_pos (
    .clk   (clk),
    .rst   (rst),
    .step  (issue),
    .eff_w (eff_w),
    .eff_h (eff_h),
    .slot  (out_slot),
    .flags (out_flags)
  );

`ifndef NO_ASSERTIONS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(DELAY_CAP))
    else $error("delay fill count above capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    rd_ptr < DA_W'(DELAY_CAP) && wr_ptr < DA_W'(DELAY_CAP))
    else $error("delay pointer out of range");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    ((PEND_W + 1)'(rd_ptr) + (PEND_W + 1)'(pending) == (PEND_W + 1)'(wr_ptr))
    || ((PEND_W + 1)'(rd_ptr) + (PEND_W + 1)'(pending)
        == (PEND_W + 1)'(wr_ptr) + (PEND_W + 1)'(DELAY_CAP)))
    else $error("delay pointers disagree with fill count");
`endif

endmodule

[src/mpix_outq.sv]
// memory read stage and output register with stall handling
`timescale 1ns / 1ps
module mpix_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      issue,
  input  mpix_pkg::mpix_meta_t      meta,
  input  logic [mpix_pkg::PX_W-1:0] dly_rdata,
  input  logic [mpix_pkg::PX_W-1:0] ctr_rdata,
  output logic                      can_take,
  output logic                      mosaic_valid,
  input  logic                      mosaic_ready,
  output mpix_pkg::mpix_out_t       mosaic
);
  import mpix_pkg::*;

  logic            s1_valid;
  mpix_meta_t      s1_meta;
  logic            move;
  logic [PX_W-1:0] px_sel;

  // read data waits in the memories until the output register frees up
  assign move     = s1_valid && (!mosaic_valid || mosaic_ready);
  assign can_take = !s1_valid || move;

  // pick center, forwarded center or delayed pixel
  assign px_sel = !s1_meta.use_center ? dly_rdata
                : (s1_meta.fwd ? s1_meta.fwd_px : ctr_rdata);

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta <= meta;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mosaic_valid <= 1'b0;
    end else if (move) begin
      mosaic_valid <= 1'b1;
    end else if (mosaic_ready) begin
      mosaic_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      mosaic.out_ch0 <= px_sel[CH_W-1:0];
      mosaic.out_ch1 <= px_sel[2*CH_W-1:CH_W];
      mosaic.out_ch2 <= px_sel[3*CH_W-1:2*CH_W];
      mosaic.last    <= s1_meta.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_issue_room: assert property (@(posedge clk) disable iff (rst)
    issue |-> can_take)
    else $error("read issued with no room in the read stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !move |=> s1_valid && $stable(s1_meta))
    else $error("stalled read stage lost its word");
`endif

endmodule

[src/block_mosaic_pixelation_top.sv]
// mosaic pixelation top level: center-sample squares over a delayed raster
// output path: a word is shown after the input word that releases it passes the memory read
// and the output register; the stream lags by HALF rows plus HALF pixels
// throughput: one input word per cycle unless the output stalls, set by one delay memory access per word
// reset: synchronous, clears positions, fill count, pointers and registers (1280 x 720);
// delay and center memories are not cleared and need no clearing pass
`timescale 1ns / 1ps
module block_mosaic_pixelation_top #(
  parameter int BLOCK     = mpix_pkg::BLOCK_DEF,
  parameter int MAX_WIDTH = mpix_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input words
  input  logic                       pixel_valid,
  output logic                       pixel_ready,
  input  mpix_pkg::mpix_in_t         pixel,
  // output words
  output logic                       mosaic_valid,
  input  logic                       mosaic_ready,
  output mpix_pkg::mpix_out_t        mosaic,
  // register writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  mpix_pkg::mpix_reg_t        cfg_index,
  input  logic [mpix_pkg::CFG_W-1:0] cfg_data
);
  import mpix_pkg::*;

  localparam int HALF         = (BLOCK - 1) / 2;
  localparam int DELAY_CAP    = HALF * MAX_WIDTH + HALF;
  localparam int CENTER_RAW   = MAX_WIDTH / BLOCK;
  localparam int CENTER_SLOTS = (CENTER_RAW > 0) ? CENTER_RAW : 1;
  localparam int DA_W         = (DELAY_CAP > 1) ? $clog2(DELAY_CAP) : 1;
  localparam int CA_W         = (CENTER_SLOTS > 1) ? $clog2(CENTER_SLOTS) : 1;

  logic             dly_we;
  logic [DA_W-1:0]  dly_waddr;
  logic             dly_re;
  logic [DA_W-1:0]  dly_raddr;
  logic [PX_W-1:0]  dly_rdata;
  logic             ctr_we;
  logic [CA_W-1:0]  ctr_waddr;
  logic             ctr_re;
  logic [CA_W-1:0]  ctr_raddr;
  logic [PX_W-1:0]  ctr_rdata;
  logic [PX_W-1:0]  px;
  logic             issue;
  logic             can_take;
  mpix_meta_t       meta;

  // registers are always writable
  assign cfg_ready = 1'b1;

  mpix_ctrl #(
    .BLOCK     (BLOCK),
    .MAX_WIDTH (MAX_WIDTH),
    .DA_W      (DA_W),
    .CA_W      (CA_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .can_take    (can_take),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dly_we      (dly_we),
    .dly_waddr   (dly_waddr),
    .dly_re      (dly_re),
    .dly_raddr   (dly_raddr),
    .ctr_we      (ctr_we),
    .ctr_waddr   (ctr_waddr),
    .ctr_re      (ctr_re),
    .ctr_raddr   (ctr_raddr),
    .px          (px),
    .issue       (issue),
    .meta        (meta)
  );

  // pixels in flight
  mpix_ram #(
    .WIDTH  (PX_W),
    .DEPTH  (DELAY_CAP),
    .ADDR_W (DA_W)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (px),
    .re    (dly_re),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  // one center pixel per column of full squares
  mpix_ram #(
    .WIDTH  (PX_W),
    .DEPTH  (CENTER_SLOTS),
    .ADDR_W (CA_W)
  ) u_center_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (px),
    .re    (ctr_re),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  mpix_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .meta         (meta),
    .dly_rdata    (dly_rdata),
    .ctr_rdata    (ctr_rdata),
    .can_take     (can_take),
    .mosaic_valid (mosaic_valid),
    .mosaic_ready (mosaic_ready),
    .mosaic       (mosaic)
  );

endmodule
